/* src/qfa_pkg.sv */
// Package for the Q16 fixed-point ALU: operation codes, pipeline payload
// type and sizing constants. No dependencies.
`timescale 1ns / 1ps
package qfa_pkg;

  localparam logic [3:0] FN_ADD       = 4'd0;
  localparam logic [3:0] FN_SUB       = 4'd1;
  localparam logic [3:0] FN_ALIGN_ADD = 4'd2;
  localparam logic [3:0] FN_ALIGN_SUB = 4'd3;
  localparam logic [3:0] FN_MUL_SHIFT = 4'd4;
  localparam logic [3:0] FN_MUL_MIN   = 4'd5;
  localparam logic [3:0] FN_DIV_SHIFT = 4'd6;
  localparam logic [3:0] FN_DIV_SCALE = 4'd7;
  localparam logic [3:0] FN_NORMALIZE = 4'd8;

  // What the item still needs before it is finished.
  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;

  // Divider: 32 quotient bits, four per stage.
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS  = 4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] res;
    logic signed [4:0]  delta;
    logic               sat;
    logic               dz;
    logic signed [31:0] prod;
    logic [3:0]         mshift;
    logic [16:0]        rem;
    logic [31:0]        dq;
    logic [15:0]        dvs;
    logic               qneg;
  } pipe_t;

endpackage

/* src/qfa_if.sv */
// Channel interfaces of the Q16 fixed-point ALU: operation in, result out.
// No package dependency.
`timescale 1ns / 1ps
interface qfa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [15:0] operand_a;
  logic signed [15:0] operand_b;
  logic [3:0]         scale_a;
  logic [3:0]         scale_b;
  logic [3:0]         shift;
  logic signed [31:0] wide_value;
  modport source(output valid, func, operand_a, operand_b, scale_a, scale_b, shift,
                 wide_value, input ready);
  modport sink(input valid, func, operand_a, operand_b, scale_a, scale_b, shift,
               wide_value, output ready);
endinterface

interface qfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result;
  logic signed [4:0]  scale_delta;
  logic               saturated;
  logic               div_by_zero;
  modport source(output valid, result, scale_delta, saturated, div_by_zero, input ready);
  modport sink(input valid, result, scale_delta, saturated, div_by_zero, output ready);
endinterface

/* src/qfa_prep.sv */
// Front-end decode of the Q16 fixed-point ALU: finishes add, subtract and
// normalize, and prepares multiply and divide work. Uses qfa_pkg.
`timescale 1ns / 1ps
module qfa_prep (
  input  logic [3:0]         func,
  input  logic signed [15:0] operand_a,
  input  logic signed [15:0] operand_b,
  input  logic [3:0]         scale_a,
  input  logic [3:0]         scale_b,
  input  logic [3:0]         shift,
  input  logic signed [31:0] wide_value,
  output qfa_pkg::pipe_t     prep
);

  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [16:0]        sum;
  logic [3:0]         dsh;
  logic [15:0]        amag;
  logic [32:0]        mag;
  logic [31:0]        lsh;
  logic [31:0]        rsh;

  always_comb begin
    prep        = '0;
    prep.kind   = qfa_pkg::KIND_DONE;
    x           = operand_a;
    y           = operand_b;
    sum         = '0;
    dsh         = shift;
    amag        = '0;
    mag         = '0;
    lsh         = '0;
    rsh         = '0;
    unique case (func) inside
      qfa_pkg::FN_ADD, qfa_pkg::FN_SUB, qfa_pkg::FN_ALIGN_ADD, qfa_pkg::FN_ALIGN_SUB: begin
        if (func[0]) begin
          y = 16'(-operand_b);
        end
        if (func[1]) begin
          if (scale_a > scale_b) begin
            x = operand_a >>> (scale_a - scale_b);
          end else begin
            y = y >>> (scale_b - scale_a);
          end
        end
        sum = {x[15], x} + {y[15], y};
        if (sum[16] != sum[15]) begin
          prep.sat = 1'b1;
          prep.res = sum[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
          prep.res = sum[15:0];
        end
      end
      qfa_pkg::FN_MUL_SHIFT, qfa_pkg::FN_MUL_MIN: begin
        prep.kind   = qfa_pkg::KIND_MUL;
        prep.prod   = 32'(operand_a) * 32'(operand_b);
        prep.mshift = (func == qfa_pkg::FN_MUL_SHIFT) ? shift :
                      ((scale_a < scale_b) ? scale_a : scale_b);
      end
      qfa_pkg::FN_DIV_SHIFT, qfa_pkg::FN_DIV_SCALE: begin
        prep.kind = qfa_pkg::KIND_DIV;
        dsh       = (func == qfa_pkg::FN_DIV_SHIFT) ? shift : scale_b;
        amag      = operand_a[15] ? 16'(-operand_a) : operand_a;
        prep.dq   = {16'd0, amag} << dsh;
        prep.dvs  = operand_b[15] ? 16'(-operand_b) : operand_b;
        prep.qneg = operand_a[15] ^ operand_b[15];
        prep.dz   = (operand_b == 16'sd0);
      end
      qfa_pkg::FN_NORMALIZE: begin
        mag = wide_value[31] ? 33'(-{wide_value[31], wide_value})
                             : {wide_value[31], wide_value};
        lsh = wide_value;
        rsh = wide_value;
        if (mag < 33'd16) begin
          lsh = wide_value << 11;  prep.delta = 5'sd11;
        end else if (mag < 33'd256) begin
          lsh = wide_value << 7;   prep.delta = 5'sd7;
        end else if (mag < 33'd4096) begin
          lsh = wide_value << 3;   prep.delta = 5'sd3;
        end else if (mag < 33'd32768) begin
          prep.delta = 5'sd0;
        end else if (mag < 33'd524288) begin
          rsh = wide_value >>> 4;  prep.delta = -5'sd4;
        end else if (mag < 33'd8388608) begin
          rsh = wide_value >>> 8;  prep.delta = -5'sd8;
        end else if (mag < 33'd134217728) begin
          rsh = wide_value >>> 12; prep.delta = -5'sd12;
        end else begin
          rsh = wide_value >>> 16; prep.delta = -5'sd16;
        end
        prep.res = (prep.delta > 5'sd0) ? lsh[15:0] : rsh[15:0];
      end
      default: begin
        prep.res = '0;
      end
    endcase
  end

endmodule

/* src/qfa_div_stage.sv */
// One registered stage of the Q16 ALU pipeline: four restoring-division steps,
// and optionally the multiply shift and clip. Uses qfa_pkg.
`timescale 1ns / 1ps
module qfa_div_stage #(
  parameter bit MUL_FIN = 1'b0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  output logic           ready_out,
  input  qfa_pkg::pipe_t data_in,
  output logic           valid_out,
  input  logic           ready_in,
  output qfa_pkg::pipe_t data_out
);

  logic           valid_r;
  qfa_pkg::pipe_t data_r;
  qfa_pkg::pipe_t data_nxt;
  logic [31:0]    prod_sh;

  always_comb begin
    data_nxt = data_in;
    prod_sh  = 32'(data_in.prod >>> data_in.mshift);
    for (int i = 0; i < qfa_pkg::DIV_STEPS; i++) begin
      data_nxt.rem = {data_nxt.rem[15:0], data_nxt.dq[31]};
      data_nxt.dq  = {data_nxt.dq[30:0], 1'b0};
      if (data_nxt.rem >= {1'b0, data_nxt.dvs}) begin
        data_nxt.rem   = data_nxt.rem - {1'b0, data_nxt.dvs};
        data_nxt.dq[0] = 1'b1;
      end
    end
    if (MUL_FIN && data_in.kind == qfa_pkg::KIND_MUL) begin
      data_nxt.kind = qfa_pkg::KIND_DONE;
      if (prod_sh[31:15] != {17{prod_sh[31]}}) begin
        data_nxt.sat = 1'b1;
        data_nxt.res = prod_sh[31] ? 16'sh8000 : 16'sh7fff;
      end else begin
        data_nxt.res = prod_sh[15:0];
      end
    end
  end

  assign ready_out = !valid_r || ready_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

/* src/q16_fixed_point_alu.sv */
// Top level of the Q16 fixed-point ALU: decode stage, divider pipeline and
// output register. Uses qfa_pkg, qfa_if, qfa_prep and qfa_div_stage.
`timescale 1ns / 1ps
// The ALU takes one item per cycle while the output side keeps up. Every
// operation travels the same ten-stage pipe, so results leave in the order
// the items came in. The depth is set by the divider, which produces four
// quotient bits per stage over eight stages; add, subtract and normalize
// finish in the first stage, and multiply finishes in the second, after the
// registered product. Each stage holds while the stage after it is full and
// stalled, so a stalled result never loses or repeats an item, and empty
// stages ahead of a stall still take new items.
module q16_fixed_point_alu (
  input logic      clk,
  input logic      rst_n,
  qfa_in_if.sink   in_ch,
  qfa_out_if.source out_ch
);

  localparam int NS = qfa_pkg::DIV_STAGES;

  qfa_pkg::pipe_t prep;
  qfa_pkg::pipe_t s1_r;
  logic           s1_valid_r;
  logic           s1_ready;

  qfa_pkg::pipe_t dv [NS+1];
  logic           vv [NS+1];
  logic           rr [NS+1];

  logic               out_valid_r;
  logic signed [15:0] out_res_r;
  logic signed [4:0]  out_delta_r;
  logic               out_sat_r;
  logic               out_dz_r;
  logic               last_ready;
  logic signed [15:0] fin_res;

  qfa_prep u_prep (
    .func       (in_ch.func),
    .operand_a  (in_ch.operand_a),
    .operand_b  (in_ch.operand_b),
    .scale_a    (in_ch.scale_a),
    .scale_b    (in_ch.scale_b),
    .shift      (in_ch.shift),
    .wide_value (in_ch.wide_value),
    .prep       (prep)
  );

  // Decode stage register.
  assign s1_ready     = !s1_valid_r || rr[0];
  assign in_ch.ready  = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_r <= prep;
    end
  end

  assign dv[0] = s1_r;
  assign vv[0] = s1_valid_r;

  // Divider stages; the first one also completes multiplies.
  for (genvar i = 0; i < NS; i++) begin : g_div
    qfa_div_stage #(
      .MUL_FIN (i == 0)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (vv[i]),
      .ready_out (rr[i]),
      .data_in   (dv[i]),
      .valid_out (vv[i+1]),
      .ready_in  (rr[i+1]),
      .data_out  (dv[i+1])
    );
  end

  // Output register: apply the quotient sign and the zero-divisor repair.
  assign last_ready = !out_valid_r || out_ch.ready;
  assign rr[NS]     = last_ready;

  always_comb begin
    fin_res = dv[NS].res;
    if (dv[NS].kind == qfa_pkg::KIND_DIV) begin
      if (dv[NS].dz) begin
        fin_res = '0;
      end else if (dv[NS].qneg) begin
        fin_res = 16'(-dv[NS].dq[15:0]);
      end else begin
        fin_res = dv[NS].dq[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_ready) begin
      out_valid_r <= vv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && vv[NS]) begin
      out_res_r   <= fin_res;
      out_delta_r <= dv[NS].delta;
      out_sat_r   <= dv[NS].sat;
      out_dz_r    <= dv[NS].dz;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result      = out_res_r;
  assign out_ch.scale_delta = out_delta_r;
  assign out_ch.saturated   = out_sat_r;
  assign out_ch.div_by_zero = out_dz_r;

  // A zero divisor always yields a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_res_r == 16'sd0)
    else $error("divide by zero result not zero");

  // Only normalize reports a scale change, and it never saturates or divides.
  a_delta_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_delta_r != 5'sd0 |-> !out_sat_r && !out_dz_r)
    else $error("scale change on a non-normalize result");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_sat_r && out_dz_r))
    else $error("saturated and divide by zero both set");

  // With the last stage full and the output stalled, nothing leaves it.
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && vv[NS] && !out_ch.ready |-> !rr[NS])
    else $error("last stage advanced into a stalled output");

  // No item reaches the output still waiting for its multiply.
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    vv[NS] |-> dv[NS].kind != qfa_pkg::KIND_MUL)
    else $error("multiply not finished at pipe end");

endmodule
